[sv/psrd_pkg.sv]
// Shared types and constants for the paletted sprite run-length decoder.
// No dependencies.
`default_nettype none
package psrd_pkg;

  localparam int unsigned MAX_DIM_DEF       = 2048;
  localparam int unsigned PALETTE_DEPTH_DEF = 256;

  localparam int unsigned DIM_W     = 12;
  localparam int unsigned PAL_LEN_W = 9;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned COLOR_W   = 24;
  localparam int unsigned PIX_IDX_W = 22;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0] RUN_LIMIT = 8'd128;

  localparam logic FUNC_PAL  = 1'b0;
  localparam logic FUNC_DATA = 1'b1;

  localparam logic KIND_PIX  = 1'b0;
  localparam logic KIND_STAT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAL_LEN = 2'd2;

  typedef struct packed {
    logic pix;
    logic stat;
    logic ok;
  } res_flags_t;

endpackage
`default_nettype wire

[sv/psrd_step.sv]
// Per-byte decode step: next position and run count, and which results the byte causes.
// Depends on psrd_pkg.
`default_nettype none
module psrd_step
  import psrd_pkg::*;
#(
  parameter int unsigned PosW = 23
) (
  input  wire logic [PosW-1:0]      pos_i,
  input  wire logic [BYTE_W-1:0]    run_i,
  input  wire logic [PosW-1:0]      total_i,
  input  wire logic [PAL_LEN_W-1:0] pal_len_i,
  input  wire logic [BYTE_W-1:0]    byte_i,
  input  wire logic                 eof_i,
  output logic      [PosW-1:0]      pos_o,
  output logic      [BYTE_W-1:0]    run_o,
  output res_flags_t                flags_o
);

  logic [PosW:0]   skip_pos;
  logic [PosW-1:0] pos_mid;
  logic [BYTE_W-1:0] run_mid;
  logic            pix;

  always_comb begin
    skip_pos = {1'b0, pos_i} + (PosW+1)'(byte_i - RUN_LIMIT);
    pos_mid  = pos_i;
    run_mid  = run_i;
    pix      = 1'b0;
    if (pos_i < total_i) begin
      if (run_i == '0) begin
        if (byte_i <= RUN_LIMIT) begin
          run_mid = byte_i;
        end else if (skip_pos > {1'b0, total_i}) begin
          pos_mid = total_i;
        end else begin
          pos_mid = skip_pos[PosW-1:0];
        end
      end else begin
        pix     = ({1'b0, byte_i} < pal_len_i);
        pos_mid = pos_i + PosW'(1);
        run_mid = run_i - BYTE_W'(1);
      end
    end
  end

  always_comb begin
    flags_o.pix  = pix;
    flags_o.stat = eof_i;
    flags_o.ok   = (run_mid == '0);
    if (eof_i) begin
      pos_o = '0;
      run_o = '0;
    end else begin
      pos_o = pos_mid;
      run_o = run_mid;
    end
  end

endmodule
`default_nettype wire

[sv/paletted_sprite_rle_decode_top.sv]
// Paletted sprite RLE decoder, top level: config registers, palette memory, output stages.
// Depends on psrd_pkg and psrd_step.
// Accepted items pass the pending stage (palette read at accept), then the output register.
// Throughput: 1 item per cycle unless output stalls; a pixel-plus-status item stalls input.
// Reset clears control state and config (width 1, height 1, palette length 0);
// palette memory contents are undefined until written.
`default_nettype none
module paletted_sprite_rle_decode_top
  import psrd_pkg::*;
#(
  parameter int unsigned MAX_DIM       = MAX_DIM_DEF,
  parameter int unsigned PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,

  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [DIM_W-1:0]     cfg_data_i,

  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 func_i,
  input  wire logic [BYTE_W-1:0]    palette_index_i,
  input  wire logic [BYTE_W-1:0]    palette_blue_i,
  input  wire logic [BYTE_W-1:0]    palette_green_i,
  input  wire logic [BYTE_W-1:0]    palette_red_i,
  input  wire logic [BYTE_W-1:0]    data_byte_i,
  input  wire logic                 end_of_frame_i,

  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic                      kind_o,
  output logic [PIX_IDX_W-1:0]      pixel_index_o,
  output logic [BYTE_W-1:0]         blue_o,
  output logic [BYTE_W-1:0]         green_o,
  output logic [BYTE_W-1:0]         red_o,
  output logic                      frame_ok_o,
  output logic                      last_o
);

  localparam int unsigned DimW = $clog2(MAX_DIM + 1);
  localparam int unsigned PosW = $clog2(MAX_DIM * MAX_DIM + 1);
  localparam int unsigned PalW = $clog2(PALETTE_DEPTH);

  function automatic logic [DimW-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DimW-1:0] r;
    if (v > MAX_DIM) begin
      r = DimW'(MAX_DIM);
    end else begin
      r = DimW'(v);
    end
    return r;
  endfunction

  // config
  logic [DIM_W-1:0]     width_q, height_q;
  logic [PAL_LEN_W-1:0] pal_len_q;
  logic [PosW-1:0]      total_q;
  logic                 cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= DIM_W'(1);
      height_q  <= DIM_W'(1);
      pal_len_q <= '0;
      total_q   <= PosW'(1);
    end else if (cfg_we) begin
      case (cfg_index_i)
        CFG_WIDTH: begin
          width_q <= cfg_data_i;
          total_q <= PosW'(clamp_dim(cfg_data_i)) * PosW'(clamp_dim(height_q));
        end
        CFG_HEIGHT: begin
          height_q <= cfg_data_i;
          total_q  <= PosW'(clamp_dim(width_q)) * PosW'(clamp_dim(cfg_data_i));
        end
        CFG_PAL_LEN: pal_len_q <= cfg_data_i[PAL_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // decode state
  logic [PosW-1:0]   pos_q, pos_d;
  logic [BYTE_W-1:0] run_q, run_d;
  res_flags_t        flags;
  logic              in_acc, data_acc, pal_acc;

  psrd_step #(.PosW(PosW)) u_step (
    .pos_i     (pos_q),
    .run_i     (run_q),
    .total_i   (total_q),
    .pal_len_i (pal_len_q),
    .byte_i    (data_byte_i),
    .eof_i     (end_of_frame_i),
    .pos_o     (pos_d),
    .run_o     (run_d),
    .flags_o   (flags)
  );

  assign in_acc   = in_valid_i && in_ready_o;
  assign data_acc = in_acc && (func_i == FUNC_DATA);
  assign pal_acc  = in_acc && (func_i == FUNC_PAL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      run_q <= '0;
    end else if (data_acc) begin
      pos_q <= pos_d;
      run_q <= run_d;
    end
  end

  // palette memory
  logic [COLOR_W-1:0] pal_mem [PALETTE_DEPTH];
  logic [COLOR_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (pal_acc) begin
      pal_mem[palette_index_i[PalW-1:0]] <= {palette_red_i, palette_green_i, palette_blue_i};
    end
    if (data_acc) begin
      rd_q <= pal_mem[data_byte_i[PalW-1:0]];
    end
  end

  // pending stage: one decoded item, up to two results
  logic                 p_valid_q, p_valid_d;
  res_flags_t           p_flags_q, p_flags_d;
  logic [PIX_IDX_W-1:0] p_idx_q;
  logic                 p_load, p_move, out_free;

  assign p_load   = data_acc && (flags.pix || flags.stat);
  assign out_free = !out_valid_o || out_ready_i;
  assign p_move   = p_valid_q && out_free;

  assign in_ready_o = !p_valid_q || (p_move && !(p_flags_q.pix && p_flags_q.stat));

  always_comb begin
    p_valid_d = p_valid_q;
    p_flags_d = p_flags_q;
    if (p_move) begin
      if (p_flags_q.pix) begin
        p_flags_d.pix = 1'b0;
        p_valid_d     = p_flags_q.stat;
      end else begin
        p_valid_d = 1'b0;
      end
    end
    if (p_load) begin
      p_valid_d = 1'b1;
      p_flags_d = flags;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      p_flags_q <= '0;
    end else begin
      p_valid_q <= p_valid_d;
      p_flags_q <= p_flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_load) begin
      p_idx_q <= PIX_IDX_W'(pos_q);
    end
  end

  // output register
  logic                 o_valid_q;
  logic                 o_kind_q, o_ok_q, o_last_q;
  logic [PIX_IDX_W-1:0] o_idx_q;
  logic [COLOR_W-1:0]   o_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (out_free) begin
      o_valid_q <= p_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_move) begin
      if (p_flags_q.pix) begin
        o_kind_q  <= KIND_PIX;
        o_idx_q   <= p_idx_q;
        o_color_q <= rd_q;
        o_ok_q    <= 1'b0;
        o_last_q  <= !p_flags_q.stat;
      end else begin
        o_kind_q  <= KIND_STAT;
        o_idx_q   <= '0;
        o_color_q <= '0;
        o_ok_q    <= p_flags_q.ok;
        o_last_q  <= 1'b1;
      end
    end
  end

  assign out_valid_o   = o_valid_q;
  assign kind_o        = o_kind_q;
  assign pixel_index_o = o_idx_q;
  assign blue_o        = o_color_q[7:0];
  assign green_o       = o_color_q[15:8];
  assign red_o         = o_color_q[23:16];
  assign frame_ok_o    = o_ok_q;
  assign last_o        = o_last_q;

  // checks
  a_pend_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_valid_q |-> (p_flags_q.pix || p_flags_q.stat))
    else $error("pending item without result");

  a_run_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q <= RUN_LIMIT)
    else $error("run count above limit");

  a_pix_no_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_valid_q && o_kind_q == KIND_PIX) |-> !o_ok_q)
    else $error("pixel result with frame_ok set");

  a_stat_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_valid_q && o_kind_q == KIND_STAT) |-> o_last_q)
    else $error("status result not marked last");

endmodule
`default_nettype wire

[verif/psrd_decode_checker.sv]
// Checker for the paletted sprite RLE decoder: tracks config and palette items,
// predicts pixel writes and frame status items, and compares them with the output.
// Depends on psrd_pkg.
module psrd_decode_checker
  import psrd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0]     cfg_data_i,

  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic                 func_i,
  input  logic [BYTE_W-1:0]    palette_index_i,
  input  logic [BYTE_W-1:0]    palette_blue_i,
  input  logic [BYTE_W-1:0]    palette_green_i,
  input  logic [BYTE_W-1:0]    palette_red_i,
  input  logic [BYTE_W-1:0]    data_byte_i,
  input  logic                 end_of_frame_i,

  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic                 kind_i,
  input  logic [PIX_IDX_W-1:0] pixel_index_i,
  input  logic [BYTE_W-1:0]    blue_i,
  input  logic [BYTE_W-1:0]    green_i,
  input  logic [BYTE_W-1:0]    red_i,
  input  logic                 frame_ok_i,
  input  logic                 last_i,

  output int                   mismatches_o,
  output int                   results_owed_o
);

  typedef struct packed {
    logic                 kind;
    logic [PIX_IDX_W-1:0] pixel_index;
    logic [BYTE_W-1:0]    blue;
    logic [BYTE_W-1:0]    green;
    logic [BYTE_W-1:0]    red;
    logic                 frame_ok;
    logic                 last;
  } decode_result_t;

  decode_result_t       owed_results[$];
  logic [DIM_W-1:0]     frame_w;
  logic [DIM_W-1:0]     frame_h;
  logic [PAL_LEN_W-1:0] pal_len;
  logic [COLOR_W-1:0]   palette [PALETTE_DEPTH_DEF];
  int unsigned          position;
  int unsigned          run_left;

  function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] d);
    return (d > MAX_DIM_DEF) ? MAX_DIM_DEF : 32'(d);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
    mismatches_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    decode_result_t got;
    decode_result_t want;
    decode_result_t pix;
    decode_result_t stat;
    logic           have_pix;
    logic           have_stat;
    logic [COLOR_W-1:0] color;
    int unsigned    span;
    if (!rst_ni) begin
      frame_w  = DIM_W'(1);
      frame_h  = DIM_W'(1);
      pal_len  = '0;
      position = 0;
      run_left = 0;
      owed_results.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = {kind_i, pixel_index_i, blue_i, green_i, red_i, frame_ok_i, last_i};
        if (owed_results.size() == 0) begin
          report_mismatch("item with no result owed", 64'(got), '0);
        end else begin
          want = owed_results.pop_front();
          if (got.kind != want.kind)
            report_mismatch("kind", 64'(got.kind), 64'(want.kind));
          if (got.pixel_index != want.pixel_index)
            report_mismatch("pixel_index", 64'(got.pixel_index), 64'(want.pixel_index));
          if (got.blue != want.blue)
            report_mismatch("blue", 64'(got.blue), 64'(want.blue));
          if (got.green != want.green)
            report_mismatch("green", 64'(got.green), 64'(want.green));
          if (got.red != want.red)
            report_mismatch("red", 64'(got.red), 64'(want.red));
          if (got.frame_ok != want.frame_ok)
            report_mismatch("frame_ok", 64'(got.frame_ok), 64'(want.frame_ok));
          if (got.last != want.last)
            report_mismatch("last", 64'(got.last), 64'(want.last));
        end
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_WIDTH: begin
            frame_w = cfg_data_i;
          end
          CFG_HEIGHT: begin
            frame_h = cfg_data_i;
          end
          CFG_PAL_LEN: begin
            pal_len = cfg_data_i[PAL_LEN_W-1:0];
          end
          default: begin
          end
        endcase
      end

      if (in_valid_i && in_ready_i) begin
        if (func_i == FUNC_PAL) begin
          palette[palette_index_i] = {palette_red_i, palette_green_i, palette_blue_i};
        end else begin
          have_pix  = 1'b0;
          have_stat = 1'b0;
          pix       = '0;
          stat      = '0;
          span      = clamp_dim(frame_w) * clamp_dim(frame_h);
          if (position < span) begin
            if (run_left == 0) begin
              if (data_byte_i <= RUN_LIMIT) begin
                run_left = 32'(data_byte_i);
              end else begin
                position = position + 32'(data_byte_i - RUN_LIMIT);
                if (position > span) position = span;
              end
            end else begin
              if ({1'b0, data_byte_i} < pal_len) begin
                color           = palette[data_byte_i];
                have_pix        = 1'b1;
                pix.kind        = KIND_PIX;
                pix.pixel_index = position[PIX_IDX_W-1:0];
                pix.blue        = color[7:0];
                pix.green       = color[15:8];
                pix.red         = color[23:16];
              end
              position++;
              run_left--;
            end
          end
          if (end_of_frame_i) begin
            have_stat     = 1'b1;
            stat.kind     = KIND_STAT;
            stat.frame_ok = (run_left == 0);
            stat.last     = 1'b1;
            position      = 0;
            run_left      = 0;
          end
          if (have_pix) begin
            pix.last = !have_stat;
            owed_results.push_back(pix);
          end
          if (have_stat) owed_results.push_back(stat);
        end
      end
    end
    results_owed_o = owed_results.size();
  end

endmodule

[verif/tb_paletted_sprite_rle_decode_top.sv]
// Testbench top for the paletted sprite RLE decoder: drives config, palette and
// frame byte items with random gaps and output stalls; verdict from psrd_decode_checker.
// Depends on psrd_pkg, paletted_sprite_rle_decode_top and psrd_decode_checker.
module tb_paletted_sprite_rle_decode_top;
  import psrd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic                 func_in;
  logic [BYTE_W-1:0]    pal_index;
  logic [BYTE_W-1:0]    pal_blue;
  logic [BYTE_W-1:0]    pal_green;
  logic [BYTE_W-1:0]    pal_red;
  logic [BYTE_W-1:0]    data_byte;
  logic                 eof;
  logic                 out_valid;
  logic                 out_ready;
  logic                 kind;
  logic [PIX_IDX_W-1:0] pixel_index;
  logic [BYTE_W-1:0]    blue;
  logic [BYTE_W-1:0]    green;
  logic [BYTE_W-1:0]    red;
  logic                 frame_ok;
  logic                 last;

  int                   mismatches;
  int                   results_owed;
  int                   items_sent;
  int unsigned          cur_pal_len;
  bit                   quiet;

  paletted_sprite_rle_decode_top dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .func_i         (func_in),
    .palette_index_i(pal_index),
    .palette_blue_i (pal_blue),
    .palette_green_i(pal_green),
    .palette_red_i  (pal_red),
    .data_byte_i    (data_byte),
    .end_of_frame_i (eof),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .kind_o         (kind),
    .pixel_index_o  (pixel_index),
    .blue_o         (blue),
    .green_o        (green),
    .red_o          (red),
    .frame_ok_o     (frame_ok),
    .last_o         (last)
  );

  psrd_decode_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .func_i         (func_in),
    .palette_index_i(pal_index),
    .palette_blue_i (pal_blue),
    .palette_green_i(pal_green),
    .palette_red_i  (pal_red),
    .data_byte_i    (data_byte),
    .end_of_frame_i (eof),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .kind_i         (kind),
    .pixel_index_i  (pixel_index),
    .blue_i         (blue),
    .green_i        (green),
    .red_i          (red),
    .frame_ok_i     (frame_ok),
    .last_i         (last),
    .mismatches_o   (mismatches),
    .results_owed_o (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  initial begin
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b1;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
        if (!quiet && $urandom_range(0, 99) < 20) stall_left = pick_gap();
      end
    end
  end

  task automatic send_item(input logic func, input logic [BYTE_W-1:0] idx,
                           input logic [BYTE_W-1:0] b, input logic [BYTE_W-1:0] g,
                           input logic [BYTE_W-1:0] r, input logic [BYTE_W-1:0] dbyte,
                           input logic flag_eof);
    int gap;
    gap = (quiet || $urandom_range(0, 99) >= 30) ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    func_in   = func;
    pal_index = idx;
    pal_blue  = b;
    pal_green = g;
    pal_red   = r;
    data_byte = dbyte;
    eof       = flag_eof;
    in_valid  = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] dbyte, input logic flag_eof);
    send_item(FUNC_DATA, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              dbyte, flag_eof);
  endtask

  task automatic send_palette(input logic [BYTE_W-1:0] idx, input logic flag_eof);
    send_item(FUNC_PAL, idx, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              flag_eof);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // drain all owed results, then let the pipeline empty before touching config
  task automatic setup(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                       input logic [DIM_W-1:0] pl);
    @(negedge clk);
    in_valid = 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_PAL_LEN, pl);
    cur_pal_len = 32'(pl[PAL_LEN_W-1:0]);
  endtask

  // one frame of runs and skips; a broken frame may end inside a run
  task automatic send_frame(input int budget, input bit whole);
    logic [BYTE_W-1:0] frame_bytes[$];
    int n;
    int room;
    int r;
    int k;
    while (frame_bytes.size() < budget) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        r = $urandom_range(0, 99);
        n = (r < 80) ? $urandom_range(1, 6) : (r < 95) ? $urandom_range(7, 20)
                                                      : $urandom_range(21, 128);
        room = budget - frame_bytes.size() - 1;
        if (whole && n > room) n = room;
        frame_bytes.push_back(n[BYTE_W-1:0]);
        repeat (n) begin
          if (cur_pal_len > 0 && $urandom_range(0, 99) < 80)
            frame_bytes.push_back(8'($urandom_range(0,
                                  (cur_pal_len > 256 ? 256 : cur_pal_len) - 1)));
          else
            frame_bytes.push_back(8'($urandom_range(0, 255)));
        end
      end else if (r < 90) begin
        frame_bytes.push_back(RUN_LIMIT + 8'($urandom_range(1, 127)));
      end else begin
        frame_bytes.push_back(8'd0);
      end
    end
    for (k = 0; k < budget; k++) send_byte(frame_bytes[k], k == budget - 1);
  endtask

  initial begin
    int phase;
    int phase_end;
    int r;
    int i;
    int drain;
    rst_n       = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    func_in     = FUNC_DATA;
    pal_index   = '0;
    pal_blue    = '0;
    pal_green   = '0;
    pal_red     = '0;
    data_byte   = '0;
    eof         = 1'b0;
    items_sent  = 0;
    cur_pal_len = 0;
    quiet       = 1'b0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // reset config: one-pixel frame, empty palette
    send_byte(8'd1, 1'b1);
    send_byte(RUN_LIMIT + 8'd1, 1'b1);

    // fill the whole palette so no literal ever reads an unwritten entry
    for (i = 0; i < PALETTE_DEPTH_DEF; i++)
      send_item(FUNC_PAL, i[BYTE_W-1:0], 8'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom), 1'($urandom_range(0, 1)));

    setup(12'd3, 12'd2, 12'd200);
    write_reg(CFG_UNUSED, 12'($urandom));
    send_byte(8'd2, 1'b0);
    send_byte(8'd0, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'd0, 1'b0);
    send_byte(RUN_LIMIT + 8'd1, 1'b0);
    send_byte(8'd1, 1'b0);
    send_byte(8'd7, 1'b1);
    send_byte(8'd5, 1'b0);
    send_byte(8'd1, 1'b0);
    send_byte(8'd1, 1'b1);
    send_byte(RUN_LIMIT + 8'd127, 1'b0);
    send_byte(8'd4, 1'b0);
    send_byte(8'd4, 1'b1);
    send_palette(8'd9, 1'b1);
    send_byte(RUN_LIMIT, 1'b0);
    send_byte(8'd199, 1'b0);
    send_byte(8'd200, 1'b1);

    for (phase = 0; phase < 11; phase++) begin
      case (phase)
        0: setup(12'd2048, 12'd2048, 12'd256);
        1: setup(12'hFFF, 12'd1, 12'hFFF);
        2: setup(12'd0, 12'd5, 12'd1);
        3: setup(12'd1, 12'd1, 12'd0);
        4: setup(12'd7, 12'hFFF, 12'd255);
        5: setup(12'd1, 12'd0, 12'd128);
        default: begin
          if ($urandom_range(0, 99) < 10)
            setup(12'($urandom_range(0, 4095)), 12'($urandom_range(1, 3)),
                  12'($urandom));
          else
            setup(12'($urandom_range(1, 8)), 12'($urandom_range(1, 6)),
                  12'($urandom_range(0, 300)));
        end
      endcase
      quiet     = (phase % 4 == 3);
      phase_end = items_sent + 20;
      while (items_sent < phase_end) begin
        r = $urandom_range(0, 99);
        if (r < 75) send_frame($urandom_range(2, 30), 1'b1);
        else if (r < 82) send_frame($urandom_range(2, 30), 1'b0);
        else if (r < 92) send_byte(8'($urandom), $urandom_range(0, 99) < 15);
        else send_palette(8'($urandom), 1'($urandom_range(0, 1)));
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    quiet    = 1'b0;
    drain    = 0;
    while (results_owed != 0 && drain < 5000) begin
      @(negedge clk);
      drain++;
    end
    repeat (10) @(negedge clk);
    if (results_owed != 0) $display("%0d results never arrived", results_owed);
    if (mismatches == 0 && results_owed == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/psrd_pkg.sv
sv/psrd_step.sv
sv/paletted_sprite_rle_decode_top.sv
verif/psrd_decode_checker.sv
verif/tb_paletted_sprite_rle_decode_top.sv
